// ===== hdl/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// bbc_pkg
// Types and constants shared by the bracket balance checker modules.
// ----------------------------------------------------------------------------
package bbc_pkg;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic        balanced;
      logic [2:0]  error_code;
      logic [10:0] final_depth;
   } rsp_type;

   // classified character handed from the front to the back
   typedef struct packed {
      logic       is_open;
      logic       is_close;
      logic [1:0] kind;
      logic       last;
   } cmd_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_MISMATCH  = 3'd1,
      ERR_UNDERFLOW = 3'd2,
      ERR_OVERFLOW  = 3'd3,
      ERR_UNCLOSED  = 3'd4
   } err_code_type;

   localparam logic [1:0] KIND_CURLY = 2'd0;
   localparam logic [1:0] KIND_PAREN = 2'd1;
   localparam logic [1:0] KIND_SQUARE = 2'd2;
   localparam logic [1:0] KIND_ANGLE = 2'd3;

   localparam logic [7:0] CHAR_LCURLY = 8'h7B;
   localparam logic [7:0] CHAR_RCURLY = 8'h7D;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_LSQUARE = 8'h5B;
   localparam logic [7:0] CHAR_RSQUARE = 8'h5D;
   localparam logic [7:0] CHAR_LANGLE = 8'h3C;
   localparam logic [7:0] CHAR_RANGLE = 8'h3E;

   localparam int FINAL_DEPTH_W = 11;

endpackage

// ===== hdl/bbc_front.sv =====
// ----------------------------------------------------------------------------
// bbc_front
// Classifies incoming characters and holds them in a two-entry command queue.
// ----------------------------------------------------------------------------
module bbc_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bbc_pkg::req_type req_data,
   output logic             full,
   output logic             cmd_valid,
   output bbc_pkg::cmd_type cmd,
   input  logic             cmd_pop
);
   import bbc_pkg::*;

   cmd_type    cmd_class;
   cmd_type    queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   always_comb begin
      cmd_class = '0;
      cmd_class.last = req_data.last_char;
      unique case (req_data.char_code)
         CHAR_LCURLY: begin
            cmd_class.is_open = 1'b1;
            cmd_class.kind    = KIND_CURLY;
         end
         CHAR_LPAREN: begin
            cmd_class.is_open = 1'b1;
            cmd_class.kind    = KIND_PAREN;
         end
         CHAR_LSQUARE: begin
            cmd_class.is_open = 1'b1;
            cmd_class.kind    = KIND_SQUARE;
         end
         CHAR_LANGLE: begin
            cmd_class.is_open = 1'b1;
            cmd_class.kind    = KIND_ANGLE;
         end
         CHAR_RCURLY: begin
            cmd_class.is_close = 1'b1;
            cmd_class.kind     = KIND_CURLY;
         end
         CHAR_RPAREN: begin
            cmd_class.is_close = 1'b1;
            cmd_class.kind     = KIND_PAREN;
         end
         CHAR_RSQUARE: begin
            cmd_class.is_close = 1'b1;
            cmd_class.kind     = KIND_SQUARE;
         end
         CHAR_RANGLE: begin
            cmd_class.is_close = 1'b1;
            cmd_class.kind     = KIND_ANGLE;
         end
         default: begin
            cmd_class.is_open = 1'b0;
         end
      endcase
   end

   assign full      = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= cmd_class;
      end
   end

endmodule

// ===== hdl/bbc_back.sv =====
// ----------------------------------------------------------------------------
// bbc_back
// Stack engine: top entry in a register, the rest in a memory with a
// prefetched second entry, plus a two-entry result queue.
// ----------------------------------------------------------------------------
module bbc_back #(
   parameter int STACK_DEPTH = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  bbc_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             empty,
   input  logic             pop,
   output bbc_pkg::rsp_type rsp_data
);
   import bbc_pkg::*;

   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam logic [DW-1:0] DEPTH_MAX = DW'(STACK_DEPTH);

   logic [1:0]    stack_mem [STACK_DEPTH];
   logic [1:0]    mem_rd_ff;
   logic          use_fwd_ff, use_fwd_in;
   logic [1:0]    fwd_ff;
   logic [1:0]    top_ff, top_in;
   logic [DW-1:0] depth_ff, depth_in, depth_nx;
   logic          err_seen_ff, err_seen_in;
   err_code_type  first_err_ff, first_err_in;
   logic [AW-1:0] rd_addr;
   logic [1:0]    second;
   logic          go, is_push, is_pop, overflow, underflow, mismatch;
   logic          new_err;
   err_code_type  new_code;
   logic          err_seen_nx;
   err_code_type  first_err_nx;
   rsp_type       rsp_in;

   rsp_type       rq_ff [2];
   logic          rq_wr_ff, rq_rd_ff;
   logic [1:0]    rq_count_ff, rq_count_in;
   logic          rq_full, rq_push, rq_pop;

   assign rq_full = (rq_count_ff == 2'd2);
   assign go      = cmd_valid && !rq_full;
   assign cmd_pop = go;

   assign is_push   = go && cmd.is_open && (depth_ff != DEPTH_MAX);
   assign overflow  = go && cmd.is_open && (depth_ff == DEPTH_MAX);
   assign is_pop    = go && cmd.is_close && (depth_ff != '0);
   assign underflow = go && cmd.is_close && (depth_ff == '0);
   assign second    = use_fwd_ff ? fwd_ff : mem_rd_ff;
   assign mismatch  = is_pop && (top_ff != cmd.kind);

   always_comb begin
      priority if (is_push) begin
         depth_nx = depth_ff + DW'(1);
         top_in   = cmd.kind;
      end else if (is_pop) begin
         depth_nx = depth_ff - DW'(1);
         top_in   = second;
      end else begin
         depth_nx = depth_ff;
         top_in   = top_ff;
      end
      rd_addr    = AW'(depth_nx - DW'(2));
      use_fwd_in = is_push;

      new_err  = overflow || underflow || mismatch;
      priority if (overflow) begin
         new_code = ERR_OVERFLOW;
      end else if (underflow) begin
         new_code = ERR_UNDERFLOW;
      end else begin
         new_code = ERR_MISMATCH;
      end
      err_seen_nx  = err_seen_ff || new_err;
      first_err_nx = (!err_seen_ff && new_err) ? new_code : first_err_ff;

      rsp_in.balanced    = !err_seen_nx && (depth_nx == '0);
      rsp_in.final_depth = FINAL_DEPTH_W'(depth_nx);
      priority if (err_seen_nx) begin
         rsp_in.error_code = first_err_nx;
      end else if (depth_nx != '0) begin
         rsp_in.error_code = ERR_UNCLOSED;
      end else begin
         rsp_in.error_code = ERR_NONE;
      end

      if (go && cmd.last) begin
         depth_in     = '0;
         err_seen_in  = 1'b0;
         first_err_in = ERR_NONE;
      end else begin
         depth_in     = depth_nx;
         err_seen_in  = err_seen_nx;
         first_err_in = first_err_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         err_seen_ff  <= 1'b0;
         first_err_ff <= ERR_NONE;
         use_fwd_ff   <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         err_seen_ff  <= err_seen_in;
         first_err_ff <= first_err_in;
         use_fwd_ff   <= use_fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      fwd_ff <= top_ff;
   end

   always_ff @(posedge clock) begin
      if (is_push && (depth_ff != '0)) begin
         stack_mem[AW'(depth_ff - DW'(1))] <= top_ff;
      end
      mem_rd_ff <= stack_mem[rd_addr];
   end

   // result queue
   assign rq_push  = go && cmd.last;
   assign empty    = (rq_count_ff == 2'd0);
   assign rq_pop   = pop && !empty;
   assign rsp_data = rq_ff[rq_rd_ff];

   always_comb begin
      rq_count_in = rq_count_ff + {1'b0, rq_push} - {1'b0, rq_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff    <= 1'b0;
         rq_rd_ff    <= 1'b0;
         rq_count_ff <= 2'd0;
      end else begin
         rq_wr_ff    <= rq_push ? ~rq_wr_ff : rq_wr_ff;
         rq_rd_ff    <= rq_pop ? ~rq_rd_ff : rq_rd_ff;
         rq_count_ff <= rq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rq_push) begin
         rq_ff[rq_wr_ff] <= rsp_in;
      end
   end

endmodule

// ===== hdl/bracket_balance_checker_top.sv =====
// ----------------------------------------------------------------------------
// bracket_balance_checker_top
// Checks bracket balance of a character stream, one verdict per expression.
// ----------------------------------------------------------------------------
// Input queue side: drive req_data and push; a transaction completes when push
// is high and full is low. Each character is one transaction; last_char marks
// the end of an expression.
// Result queue side: while empty is low, rsp_data holds the oldest verdict;
// pop high with empty low takes it. Only last characters produce a verdict.
// Throughput: one character per cycle while the result queue is not full,
// set by the stack update (top entry in a register, second entry prefetched
// from the stack memory). Verdicts are registered in the result queue.
// A stalled result side fills the two-entry result queue, then the two-entry
// command queue, after which full rises; nothing is dropped.
// Reset clears depth, error state and both queues; stack contents are left
// as they are and need no clearing pass.
// STACK_DEPTH sets the stack memory size.
// ----------------------------------------------------------------------------
module bracket_balance_checker_top #(
   parameter int STACK_DEPTH = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bbc_pkg::req_type req_data,
   output logic             full,
   output logic             empty,
   input  logic             pop,
   output bbc_pkg::rsp_type rsp_data
);
   import bbc_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;

   bbc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   bbc_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule
